// ----- rtl/y2r_pkg.sv -----
// shared types and constants for the yuyv to rgb converter
`timescale 1ns / 1ps

package y2r_pkg;

    // chroma is centred on this code
    localparam int unsigned ChromaOffset = 128;
    // fractional bits of the colour coefficients
    localparam int unsigned FracBits     = 15;
    localparam int unsigned ChannelMax   = 255;

    localparam int unsigned SampleW = 8;
    localparam int unsigned CoefW   = 18;  // signed, holds the largest coefficient
    localparam int unsigned DiffW   = 9;   // signed chroma difference
    localparam int unsigned ProdW   = 26;  // signed coefficient products and their sums
    localparam int unsigned OffW    = 11;  // signed channel offset after the shift
    localparam int unsigned SumW    = 12;  // signed luma plus offset before clamping

    localparam logic signed [CoefW-1:0] CoefRV = 18'sd37221;
    localparam logic signed [CoefW-1:0] CoefGU = 18'sd12975;
    localparam logic signed [CoefW-1:0] CoefGV = 18'sd18949;
    localparam logic signed [CoefW-1:0] CoefBU = 18'sd66883;

    typedef logic [SampleW-1:0]       t_sample;
    typedef logic signed [DiffW-1:0]  t_diff;
    typedef logic signed [ProdW-1:0]  t_prod;
    typedef logic signed [OffW-1:0]   t_off;
    typedef logic signed [SumW-1:0]   t_sum;

    // per channel offsets shared by both pixels of a macropixel
    typedef struct packed {
        t_off r;
        t_off g;  // already negated, added like the others
        t_off b;
    } t_chroma_off;

    typedef struct packed {
        t_sample b;
        t_sample g;
        t_sample r;
    } t_rgb;

endpackage

// ----- rtl/y2r_chroma.sv -----
// shared chroma stage: coefficient products, then shifted channel offsets
`timescale 1ns / 1ps

module y2r_chroma (
    input  logic                 i_clk,
    input  logic                 i_en_mul,
    input  logic                 i_en_off,
    input  y2r_pkg::t_sample     i_chroma_u,
    input  y2r_pkg::t_sample     i_chroma_v,
    output y2r_pkg::t_chroma_off o_off
);

    y2r_pkg::t_diff du;
    y2r_pkg::t_diff dv;

    y2r_pkg::t_prod r_prod_rv;
    y2r_pkg::t_prod r_prod_gu;
    y2r_pkg::t_prod r_prod_gv;
    y2r_pkg::t_prod r_prod_bu;

    y2r_pkg::t_prod       g_sum;
    y2r_pkg::t_prod       sh_r;
    y2r_pkg::t_prod       sh_g;
    y2r_pkg::t_prod       sh_b;
    y2r_pkg::t_chroma_off n_off;
    y2r_pkg::t_chroma_off r_off;

    assign du = $signed({1'b0, i_chroma_u}) - y2r_pkg::DiffW'(y2r_pkg::ChromaOffset);
    assign dv = $signed({1'b0, i_chroma_v}) - y2r_pkg::DiffW'(y2r_pkg::ChromaOffset);

    always_ff @(posedge i_clk) begin
        if (i_en_mul) begin
            r_prod_rv <= y2r_pkg::ProdW'(dv) * y2r_pkg::ProdW'(y2r_pkg::CoefRV);
            r_prod_gu <= y2r_pkg::ProdW'(du) * y2r_pkg::ProdW'(y2r_pkg::CoefGU);
            r_prod_gv <= y2r_pkg::ProdW'(dv) * y2r_pkg::ProdW'(y2r_pkg::CoefGV);
            r_prod_bu <= y2r_pkg::ProdW'(du) * y2r_pkg::ProdW'(y2r_pkg::CoefBU);
        end
    end

    // arithmetic shift floors towards minus infinity
    always_comb begin
        g_sum     = r_prod_gu + r_prod_gv;
        sh_r      = r_prod_rv >>> y2r_pkg::FracBits;
        sh_g      = g_sum >>> y2r_pkg::FracBits;
        sh_b      = r_prod_bu >>> y2r_pkg::FracBits;
        n_off.r   = sh_r[y2r_pkg::OffW-1:0];
        n_off.g   = -sh_g[y2r_pkg::OffW-1:0];
        n_off.b   = sh_b[y2r_pkg::OffW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en_off) begin
            r_off <= n_off;
        end
    end

    assign o_off = r_off;

endmodule

// ----- rtl/y2r_lane.sv -----
// one pixel lane: luma plus chroma offsets, clamped to the 8 bit range
`timescale 1ns / 1ps

module y2r_lane (
    input  y2r_pkg::t_sample     i_luma,
    input  y2r_pkg::t_chroma_off i_off,
    output y2r_pkg::t_rgb        o_rgb
);

    function automatic y2r_pkg::t_sample clamp_chan(input y2r_pkg::t_sum v);
        y2r_pkg::t_sample res;
        if (v < 0) begin
            res = '0;
        end else if (v > y2r_pkg::SumW'(y2r_pkg::ChannelMax)) begin
            res = y2r_pkg::SampleW'(y2r_pkg::ChannelMax);
        end else begin
            res = v[y2r_pkg::SampleW-1:0];
        end
        return res;
    endfunction

    y2r_pkg::t_sum luma_s;
    y2r_pkg::t_sum sum_r;
    y2r_pkg::t_sum sum_g;
    y2r_pkg::t_sum sum_b;

    always_comb begin
        luma_s  = $signed({{(y2r_pkg::SumW-y2r_pkg::SampleW){1'b0}}, i_luma});
        sum_r   = luma_s + y2r_pkg::SumW'(i_off.r);
        sum_g   = luma_s + y2r_pkg::SumW'(i_off.g);
        sum_b   = luma_s + y2r_pkg::SumW'(i_off.b);
        o_rgb.r = clamp_chan(sum_r);
        o_rgb.g = clamp_chan(sum_g);
        o_rgb.b = clamp_chan(sum_b);
    end

endmodule

// ----- rtl/yuyv_to_rgb_converter.sv -----
// top level: yuyv 4:2:2 macropixel stream in, two rgb888 pixels per transfer out
`timescale 1ns / 1ps
// path: an input transfer is registered as products, then offsets, then the output word
// throughput: one macropixel per cycle, sustained while the output side keeps taking
// the three stages (products, offsets, lanes plus output register) each hold one item
// and a stalled output only blocks the input once every stage is full
// reset: synchronous active low, clears the stage valid flags; data registers are not reset

module yuyv_to_rgb_converter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,  // luma_0, chroma_u, luma_1, chroma_v
    input  logic        i_s_axis_tlast,  // frame end marker
    // output stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata,  // red_0, green_0, blue_0, red_1, green_1, blue_1
    output logic        o_m_axis_tlast   // frame end marker, copied through
);

    // stage valid flags
    logic r_s1_vld;
    logic r_s2_vld;
    logic r_out_vld;

    // per stage readiness, each stage takes when empty or when it moves on
    logic s1_rdy;
    logic s2_rdy;
    logic s3_rdy;
    logic en1;
    logic en2;
    logic en3;

    // lumas and marker ride alongside the shared chroma path
    y2r_pkg::t_sample r_s1_luma0;
    y2r_pkg::t_sample r_s1_luma1;
    logic             r_s1_last;
    y2r_pkg::t_sample r_s2_luma0;
    y2r_pkg::t_sample r_s2_luma1;
    logic             r_s2_last;

    y2r_pkg::t_chroma_off chroma_off;
    y2r_pkg::t_rgb        lane0_rgb;
    y2r_pkg::t_rgb        lane1_rgb;
    logic [47:0]          n_out_data;
    logic [47:0]          r_out_data;
    logic                 r_out_last;

    assign s3_rdy = !r_out_vld || i_m_axis_tready;
    assign s2_rdy = !r_s2_vld || s3_rdy;
    assign s1_rdy = !r_s1_vld || s2_rdy;
    assign en1    = i_s_axis_tvalid && s1_rdy;
    assign en2    = r_s1_vld && s2_rdy;
    assign en3    = r_s2_vld && s3_rdy;

    assign o_s_axis_tready = s1_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (s1_rdy) begin
                r_s1_vld <= i_s_axis_tvalid;
            end
            if (s2_rdy) begin
                r_s2_vld <= r_s1_vld;
            end
            if (s3_rdy) begin
                r_out_vld <= r_s2_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_s1_luma0 <= i_s_axis_tdata[7:0];
            r_s1_luma1 <= i_s_axis_tdata[23:16];
            r_s1_last  <= i_s_axis_tlast;
        end
        if (en2) begin
            r_s2_luma0 <= r_s1_luma0;
            r_s2_luma1 <= r_s1_luma1;
            r_s2_last  <= r_s1_last;
        end
    end

    // shared chroma products and offsets, one set per macropixel
    y2r_chroma u_chroma (
        .i_clk      (i_clk),
        .i_en_mul   (en1),
        .i_en_off   (en2),
        .i_chroma_u (i_s_axis_tdata[15:8]),
        .i_chroma_v (i_s_axis_tdata[31:24]),
        .o_off      (chroma_off)
    );

    // two pixel lanes side by side
    y2r_lane u_lane0 (
        .i_luma (r_s2_luma0),
        .i_off  (chroma_off),
        .o_rgb  (lane0_rgb)
    );

    y2r_lane u_lane1 (
        .i_luma (r_s2_luma1),
        .i_off  (chroma_off),
        .o_rgb  (lane1_rgb)
    );

    // merge both lanes into the output word, first pixel in the low bytes
    assign n_out_data = {lane1_rgb.b, lane1_rgb.g, lane1_rgb.r,
                         lane0_rgb.b, lane0_rgb.g, lane0_rgb.r};

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_out_data <= n_out_data;
            r_out_last <= r_s2_last;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tlast  = r_out_last;

    // input only stalls when the whole pipe is full and the output is held
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> (r_s1_vld && r_s2_vld && r_out_vld && !i_m_axis_tready))
        else $error("input stalled with room in the pipe");

    // an item leaving the offset stage shows up on the output next cycle
    a_out_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        en3 |=> o_m_axis_tvalid)
        else $error("result lost between offset stage and output");

    // an accepted input occupies the first stage next cycle
    a_s1_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> r_s1_vld)
        else $error("accepted transfer not held in first stage");

endmodule

// ----- tb/sv/tb_yuyv_to_rgb_converter.sv -----
// testbench for the yuyv to rgb converter: directed and random traffic, scoreboard checked
`timescale 1ns / 1ps

module tb_yuyv_to_rgb_converter;

    // conversion constants, kept apart from the design
    localparam int ChromaMid  = 128;
    localparam int CoefRedV   = 37221;
    localparam int CoefGreenU = 12975;
    localparam int CoefGreenV = 18949;
    localparam int CoefBlueU  = 66883;
    localparam int ShiftBits  = 15;
    localparam int SampleTop  = 255;

    localparam int NumRandom   = 650;
    localparam int HoldCycles  = 300;   // long output hold-off to back the pipe up
    localparam int HoldAfter   = 200;   // input transfers before the hold-off starts
    localparam int SteadyFirst = 350;   // window with no idling on either side
    localparam int SteadyLast  = 450;
    localparam int DrainCycles = 8;     // slack after the scoreboard has drained
    localparam int CycleLimit  = 200000;

    // expected pixel pairs, oldest first, with the frame end marker on top
    class pixel_scoreboard;
        logic [48:0] pixel_pair_q[$];
        int unsigned failures;

        function new();
            failures = 0;
        endfunction

        function y2r_pkg::t_sample saturate(int v);
            if (v < 0) begin
                return '0;
            end
            if (v > SampleTop) begin
                return y2r_pkg::t_sample'(SampleTop);
            end
            return y2r_pkg::t_sample'(v);
        endfunction

        // >>> on a signed int floors, which is what the colour maths wants
        function y2r_pkg::t_rgb convert(int luma, int du, int dv);
            y2r_pkg::t_rgb px;
            px.r = saturate(luma + ((dv * CoefRedV) >>> ShiftBits));
            px.g = saturate(luma - ((du * CoefGreenU + dv * CoefGreenV) >>> ShiftBits));
            px.b = saturate(luma + ((du * CoefBlueU) >>> ShiftBits));
            return px;
        endfunction

        function void note_macropixel(logic [31:0] tdata, logic tlast);
            int            du;
            int            dv;
            y2r_pkg::t_rgb px0;
            y2r_pkg::t_rgb px1;
            du  = int'(tdata[15:8]) - ChromaMid;
            dv  = int'(tdata[31:24]) - ChromaMid;
            px0 = convert(int'(tdata[7:0]), du, dv);
            px1 = convert(int'(tdata[23:16]), du, dv);
            pixel_pair_q.push_back({tlast, px1, px0});
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                $error("%s mismatch: expected %0d, got %0d", name, want, got);
                failures++;
            end
        endfunction

        function void check_pixels(logic [47:0] tdata, logic tlast);
            logic [48:0] want;
            if (pixel_pair_q.size() == 0) begin
                $error("output transfer with nothing expected: tdata %h tlast %b",
                       tdata, tlast);
                failures++;
                return;
            end
            want = pixel_pair_q.pop_front();
            compare_field("red_0",   want[7:0],   tdata[7:0]);
            compare_field("green_0", want[15:8],  tdata[15:8]);
            compare_field("blue_0",  want[23:16], tdata[23:16]);
            compare_field("red_1",   want[31:24], tdata[31:24]);
            compare_field("green_1", want[39:32], tdata[39:32]);
            compare_field("blue_1",  want[47:40], tdata[47:40]);
            compare_field("frame_end_out", {7'd0, want[48]}, {7'd0, tlast});
        endfunction

        function int pending();
            return pixel_pair_q.size();
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [31:0] s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tready = 1'b0;
    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [47:0] o_m_axis_tdata;
    logic        o_m_axis_tlast;

    pixel_scoreboard sb = new();
    int unsigned     n_in_accepted = 0;
    int unsigned     cycle_count = 0;
    bit              steady = 1'b0;
    bit              hold_done = 1'b0;

    yuyv_to_rgb_converter dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),   // luma_0, chroma_u, luma_1, chroma_v
        .i_s_axis_tlast  (s_tlast),   // frame end marker
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),  // red_0, green_0, blue_0, red_1, green_1, blue_1
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // mostly short gaps, the odd long one, none inside the steady window
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // leans on the codes around the clamping edges and the chroma centre
    function automatic y2r_pkg::t_sample pick_sample();
        y2r_pkg::t_sample edges [7] = '{8'd0, 8'd1, 8'd127, 8'd128, 8'd129, 8'd254, 8'd255};
        if ($urandom_range(0, 99) < 15) begin
            return edges[$urandom_range(0, 6)];
        end
        return y2r_pkg::t_sample'($urandom_range(0, 255));
    endfunction

    // monitor: both sides sampled at the edge, input noted before output is checked
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_tvalid && o_s_axis_tready) begin
                sb.note_macropixel(s_tdata, s_tlast);
                n_in_accepted++;
            end
            if (o_m_axis_tvalid && m_tready) begin
                sb.check_pixels(o_m_axis_tdata, o_m_axis_tlast);
            end
        end
    end

    // one input transfer, with an optional idle gap in front of it
    task automatic send_macropixel(input y2r_pkg::t_sample y0, input y2r_pkg::t_sample u,
                                   input y2r_pkg::t_sample y1, input y2r_pkg::t_sample v,
                                   input logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {v, y1, u, y0};
        s_tlast  <= last;
        do @(posedge i_clk); while (!o_s_axis_tready);
    endtask

    // output side: runs of ready with gaps, plus one long hold-off
    initial begin : receiver
        int run;
        int gap;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (!hold_done && n_in_accepted >= HoldAfter) begin
                m_tready <= 1'b0;
                repeat (HoldCycles) @(posedge i_clk);
                hold_done = 1'b1;
            end
            run = $urandom_range(1, 20);
            m_tready <= 1'b1;
            repeat (run) @(posedge i_clk);
            gap = pick_gap();
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < CycleLimit) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("yuyv_to_rgb_converter test failed");
        $finish;
    end

    initial begin : stimulus
        int frame_left;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: zero and full codes, clamp at both ends, grey, frame end
        send_macropixel(8'd0,   8'd0,   8'd0,   8'd0,   1'b0);
        send_macropixel(8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
        send_macropixel(8'd0,   8'd128, 8'd255, 8'd128, 1'b0);
        send_macropixel(8'd16,  8'd128, 8'd235, 8'd128, 1'b0);
        send_macropixel(8'd0,   8'd0,   8'd255, 8'd255, 1'b0);
        send_macropixel(8'd255, 8'd255, 8'd0,   8'd0,   1'b1);
        send_macropixel(8'd128, 8'd0,   8'd128, 8'd0,   1'b0);
        send_macropixel(8'd128, 8'd255, 8'd128, 8'd255, 1'b0);
        send_macropixel(8'd128, 8'd0,   8'd128, 8'd255, 1'b0);
        send_macropixel(8'd128, 8'd255, 8'd128, 8'd0,   1'b1);
        send_macropixel(8'd1,   8'd127, 8'd254, 8'd129, 1'b0);
        send_macropixel(8'd254, 8'd129, 8'd1,   8'd127, 1'b0);
        send_macropixel(8'd60,  8'd90,  8'd200, 8'd240, 1'b0);
        send_macropixel(8'd200, 8'd240, 8'd60,  8'd90,  1'b1);
        send_macropixel(8'h55,  8'hAA,  8'h55,  8'hAA,  1'b0);
        send_macropixel(8'hAA,  8'h55,  8'hAA,  8'h55,  1'b1);

        // random frames of varying length, tlast on the last macropixel of each
        frame_left = $urandom_range(1, 24);
        for (int i = 0; i < NumRandom; i++) begin
            steady = (i >= SteadyFirst && i < SteadyLast);
            frame_left--;
            send_macropixel(pick_sample(), pick_sample(), pick_sample(), pick_sample(),
                            frame_left == 0);
            if (frame_left == 0) begin
                frame_left = $urandom_range(1, 24);
            end
        end
        s_tvalid <= 1'b0;
        // let the monitor note the last input transfer before draining
        @(posedge i_clk);

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);

        if (sb.failures == 0 && sb.pending() == 0) begin
            $display("yuyv_to_rgb_converter test passed");
        end else begin
            $display("yuyv_to_rgb_converter test failed");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/y2r_pkg.sv
rtl/y2r_chroma.sv
rtl/y2r_lane.sv
rtl/yuyv_to_rgb_converter.sv
tb/sv/tb_yuyv_to_rgb_converter.sv
